### design/ppmhp_pkg.sv
// shared types and constants for the ppm p6 header parser
package ppmhp_pkg;

  localparam int ValW = 17;
  localparam logic [ValW-1:0] VAL_MAX = '1;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    ST_PARSING    = 3'd0,
    ST_DONE       = 3'd1,
    ST_PAYLOAD    = 3'd2,
    ST_BAD_MAGIC  = 3'd3,
    ST_TOO_LONG   = 3'd4,
    ST_INCOMPLETE = 3'd5
  } status_t;

endpackage

### design/ppm_binary_header_parser_top.sv
// ppm p6 header parser: a byte per cycle unless stalled, one status per byte
//
// Takes a PPM file one byte per transfer and returns one result per byte: the
// parse status, the width, height and maximum color seen so far, and the byte
// itself once it belongs to the pixel payload. The stream must open with "P6"
// and a line feed; after that whitespace is skipped, comments and stray text
// are skipped to the end of the line, and the three decimal numbers are
// collected. Status 1 marks the line feed that closes the header; later bytes
// come back with status 2. Errors (bad magic, number too long, file ends in the
// header) are sticky until reset. A byte is taken when the output register is
// empty or being read, and its result appears there in the cycle after its
// transfer; the parse state update is a single pass of logic, so one byte per
// cycle is sustained as long as the result side keeps taking results.
module ppm_binary_header_parser_top #(
  parameter int DIGIT_LIMIT = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [16:0] out_image_width,
  output logic [16:0] out_image_height,
  output logic [16:0] out_max_color,
  output logic [7:0]  out_payload_byte
);

  localparam int CntW = ($clog2(DIGIT_LIMIT) < 2) ? 2 : $clog2(DIGIT_LIMIT);
  localparam logic [CntW-1:0] CntLast  = CntW'(DIGIT_LIMIT - 1);
  localparam logic [CntW-1:0] MagicEnd = CntW'(2);
  localparam int AccW = ppmhp_pkg::ValW + 4;

  typedef enum logic [2:0] {
    PH_MAGIC,
    PH_TOKEN,
    PH_SKIP,
    PH_TRAIL,
    PH_PAYLOAD,
    PH_ERR_MAGIC,
    PH_ERR_LONG,
    PH_ERR_SHORT
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic [CntW-1:0]               cnt_r, cnt_nxt;
  logic [ppmhp_pkg::ValW-1:0]    acc_r, acc_nxt;
  logic [1:0]                    fld_r, fld_nxt;
  logic [ppmhp_pkg::ValW-1:0]    wid_r, wid_nxt;
  logic [ppmhp_pkg::ValW-1:0]    hgt_r, hgt_nxt;
  logic [ppmhp_pkg::ValW-1:0]    maxc_r, maxc_nxt;

  logic                          out_valid_r;
  ppmhp_pkg::status_t            status_r, status_nxt;
  logic [7:0]                    pay_r, pay_nxt;

  logic                          in_xfer;
  logic                          is_digit, is_space, magic_ok, num_end;
  logic [7:0]                    magic_exp;
  logic [3:0]                    digit_off;
  logic [AccW-1:0]               acc_mul;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;

  assign is_digit  = (in_byte >= ppmhp_pkg::CH_ZERO) && (in_byte <= ppmhp_pkg::CH_NINE);
  assign is_space  = (in_byte == ppmhp_pkg::CH_SPACE) ||
                     ((in_byte >= ppmhp_pkg::CH_TAB) && (in_byte <= ppmhp_pkg::CH_CR));
  assign digit_off = 4'(in_byte - ppmhp_pkg::CH_ZERO);
  assign acc_mul   = (AccW'(acc_r) << 3) + (AccW'(acc_r) << 1) + AccW'(digit_off);
  assign num_end   = (cnt_r != '0);

  always_comb begin
    case (cnt_r)
      CntW'(0): magic_exp = ppmhp_pkg::CH_P;
      CntW'(1): magic_exp = ppmhp_pkg::CH_SIX;
      default:  magic_exp = ppmhp_pkg::CH_LF;
    endcase
  end

  assign magic_ok = (cnt_r <= MagicEnd) && (in_byte == magic_exp);

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    fld_nxt    = fld_r;
    wid_nxt    = wid_r;
    hgt_nxt    = hgt_r;
    maxc_nxt   = maxc_r;
    status_nxt = ppmhp_pkg::ST_PARSING;
    pay_nxt    = '0;

    unique case (phase_r)
      PH_MAGIC: begin
        if (!magic_ok) begin
          phase_nxt = PH_ERR_MAGIC;
        end else if (cnt_r == MagicEnd) begin
          cnt_nxt   = '0;
          phase_nxt = PH_TOKEN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      PH_TOKEN: begin
        if (is_digit) begin
          if (cnt_r >= CntLast) begin
            phase_nxt = PH_ERR_LONG;
          end else begin
            acc_nxt = (acc_mul > AccW'(ppmhp_pkg::VAL_MAX)) ? ppmhp_pkg::VAL_MAX
                                                            : acc_mul[ppmhp_pkg::ValW-1:0];
            cnt_nxt = cnt_r + 1'b1;
          end
        end else begin
          if (num_end) begin
            case (fld_r)
              2'd0:    wid_nxt  = acc_r;
              2'd1:    hgt_nxt  = acc_r;
              default: maxc_nxt = acc_r;
            endcase
            fld_nxt = fld_r + 1'b1;
            acc_nxt = '0;
            cnt_nxt = '0;
          end
          if (num_end && (fld_r == 2'd2)) begin
            if (in_byte == ppmhp_pkg::CH_LF) begin
              status_nxt = ppmhp_pkg::ST_DONE;
              phase_nxt  = PH_PAYLOAD;
            end else begin
              phase_nxt = PH_TRAIL;
            end
          end else if (!is_space) begin
            phase_nxt = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        if (in_byte == ppmhp_pkg::CH_LF) begin
          phase_nxt = PH_TOKEN;
        end
      end
      PH_TRAIL: begin
        if (in_byte == ppmhp_pkg::CH_LF) begin
          status_nxt = ppmhp_pkg::ST_DONE;
          phase_nxt  = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        status_nxt = ppmhp_pkg::ST_PAYLOAD;
        pay_nxt    = in_byte;
      end
      default: begin
      end
    endcase

    // end of file while still inside the header
    if (in_last_byte && (status_nxt == ppmhp_pkg::ST_PARSING) &&
        (phase_nxt == PH_MAGIC || phase_nxt == PH_TOKEN ||
         phase_nxt == PH_SKIP || phase_nxt == PH_TRAIL)) begin
      phase_nxt = PH_ERR_SHORT;
    end

    case (phase_nxt)
      PH_ERR_MAGIC: status_nxt = ppmhp_pkg::ST_BAD_MAGIC;
      PH_ERR_LONG:  status_nxt = ppmhp_pkg::ST_TOO_LONG;
      PH_ERR_SHORT: status_nxt = ppmhp_pkg::ST_INCOMPLETE;
      default:      ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_MAGIC;
      cnt_r       <= '0;
      acc_r       <= '0;
      fld_r       <= '0;
      wid_r       <= '0;
      hgt_r       <= '0;
      maxc_r      <= '0;
      out_valid_r <= 1'b0;
      status_r    <= ppmhp_pkg::ST_PARSING;
      pay_r       <= '0;
    end else begin
      if (in_xfer) begin
        phase_r  <= phase_nxt;
        cnt_r    <= cnt_nxt;
        acc_r    <= acc_nxt;
        fld_r    <= fld_nxt;
        wid_r    <= wid_nxt;
        hgt_r    <= hgt_nxt;
        maxc_r   <= maxc_nxt;
        status_r <= status_nxt;
        pay_r    <= pay_nxt;
      end
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_image_width  = wid_r;
  assign out_image_height = hgt_r;
  assign out_max_color    = maxc_r;
  assign out_payload_byte = pay_r;

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ERR_MAGIC || phase_r == PH_ERR_LONG || phase_r == PH_ERR_SHORT)
    |=> (phase_r == $past(phase_r)))
    else $error("error phase left before reset");

  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while result side is taking results");

  a_payload_only_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r != ppmhp_pkg::ST_PAYLOAD)) |-> (pay_r == '0))
    else $error("payload byte driven outside payload status");

  a_token_field_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_TOKEN) |-> (fld_r != 2'd3))
    else $error("token phase after all three numbers");

endmodule
